FILE: hw/rtl/thlf_pkg.sv
package thlf_pkg;

	// Default sizes of the block.
	localparam int CHANNELS_DEF   = 8;
	localparam int DEPTH_DEF      = 8;
	localparam int ENTRY_BITS_DEF = 32;

	// Field widths of the ports.
	localparam int OP_W     = 2;
	localparam int CHAN_W   = 3;
	localparam int WORD_W   = 32;
	localparam int FILL_W   = 4;
	localparam int CFG_IDX_W = 2;
	localparam int CFG_DAT_W = 8;
	localparam int LEVEL_W  = 4;

	// Reset value of the interrupt level register.
	localparam logic [LEVEL_W-1:0] INTR_LEVEL_RST = 4'd6;

	// Configuration register indexes.
	localparam logic [CFG_IDX_W-1:0] CFG_HIST_EN    = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_INTR_EVERY = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_INTR_LEVEL = 2'd2;

	// Operation codes of an input word.
	typedef enum logic [OP_W-1:0] {
		OP_PUT  = 2'd0,
		OP_DROP = 2'd1,
		OP_PEEK = 2'd2
	} op_t;

	// Status codes of a result word.
	typedef enum logic [1:0] {
		ST_OK       = 2'd0,
		ST_DISABLED = 2'd1,
		ST_OVERFLOW = 2'd2,
		ST_EMPTY    = 2'd3
	} status_t;

endpackage

FILE: hw/rtl/tx_history_list_fifo.sv
// Transmit history FIFO with one ring of DEPTH entry words per channel. Each input word
// puts an entry, drops the oldest entry or peeks at the oldest entry of one channel (an
// unused operation code leaves it as it is), and gives one result word with a status code,
// the peeked entry and the channel's flags and count after the operation. Words are handled
// one at a time. The per-channel state memory is read at the accepting edge, the S_EXEC
// state does the update, write-back and entry store access, and the S_OUT state loads the
// result register. in_ready returns in the cycle after the load, so a new word is taken
// only after the result of the last one is loaded. A result that waits on out_ready holds
// the next word in S_OUT. The per-channel state memory carries a valid bit per channel, so
// no clearing pass is needed after reset. Config registers are to be written through cfg_we,
// cfg_addr and cfg_wdata while the block is idle; the block itself does not enforce this.
module tx_history_list_fifo #(
	parameter int CHANNELS   = thlf_pkg::CHANNELS_DEF,
	parameter int DEPTH      = thlf_pkg::DEPTH_DEF,
	parameter int ENTRY_BITS = thlf_pkg::ENTRY_BITS_DEF
) (
	input  logic                           clk,
	input  logic                           arst_n,
	// Input channel.
	input  logic                           in_valid,
	output logic                           in_ready,
	input  logic [thlf_pkg::OP_W-1:0]      operation,
	input  logic [thlf_pkg::CHAN_W-1:0]    channel,
	input  logic [thlf_pkg::WORD_W-1:0]    entry_in,
	// Result channel.
	output logic                           out_valid,
	input  logic                           out_ready,
	output logic [1:0]                     status_code,
	output logic [thlf_pkg::WORD_W-1:0]    entry_out,
	output logic                           overflow_flag,
	output logic                           interrupt_flag,
	output logic                           full_flag,
	output logic                           empty_flag,
	output logic [thlf_pkg::FILL_W-1:0]    fill_count,
	// Configuration write port.
	input  logic                           cfg_we,
	input  logic [thlf_pkg::CFG_IDX_W-1:0] cfg_addr,
	input  logic [thlf_pkg::CFG_DAT_W-1:0] cfg_wdata
);

	localparam int PTR_W  = $clog2(DEPTH);
	localparam int CNT_W  = $clog2(DEPTH + 1);
	localparam int CH_W   = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
	localparam int ADDR_W = $clog2(CHANNELS * DEPTH);
	localparam int CMP_W  = (CNT_W > thlf_pkg::LEVEL_W) ? CNT_W : thlf_pkg::LEVEL_W;

	localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
	localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

	typedef struct packed {
		logic [PTR_W-1:0] wr_ptr;
		logic [PTR_W-1:0] rd_ptr;
		logic [CNT_W-1:0] count;
		logic             overflow;
		logic             interrupt;
		logic             full;
		logic             empty;
	} chan_st_t;

	typedef enum logic [1:0] {
		S_IDLE,
		S_EXEC,
		S_OUT
	} state_t;

	state_t state_q;

	// Configuration registers.
	logic [7:0]                      hist_en_q;
	logic [7:0]                      intr_every_q;
	logic [thlf_pkg::LEVEL_W-1:0]    intr_level_q;

	// Captured input word.
	thlf_pkg::op_t                   op_q;
	logic [thlf_pkg::CHAN_W-1:0]     ch_q;
	logic [thlf_pkg::WORD_W-1:0]     entry_q;

	// Memories.
	chan_st_t                        st_mem [CHANNELS];
	logic [ENTRY_BITS-1:0]           ent_mem [CHANNELS * DEPTH];
	logic [CHANNELS-1:0]             st_vld_q;
	chan_st_t                        st_rd_q;
	logic                            st_rd_vld_q;
	logic [ENTRY_BITS-1:0]           ent_rd_q;

	// Result held between update and output load.
	thlf_pkg::status_t               res_status_q;
	logic                            res_peek_q;
	logic                            res_ovf_q;
	logic                            res_intr_q;
	logic                            res_full_q;
	logic                            res_empty_q;
	logic [CNT_W-1:0]                res_count_q;

	logic                            accept;
	logic                            out_load;
	logic [CH_W-1:0]                 ch_idx_in;
	logic [CH_W-1:0]                 ch_idx_q;
	logic                            ch_ok;
	chan_st_t                        st_cur;
	chan_st_t                        st_nxt;
	thlf_pkg::status_t               status_nxt;
	logic                            st_we;
	logic                            ent_we;
	logic                            ent_re;
	logic [CNT_W-1:0]                cnt_inc;
	logic [CNT_W-1:0]                cnt_dec;
	logic [ADDR_W-1:0]               wr_addr;
	logic [ADDR_W-1:0]               rd_addr;

	function automatic logic ch_ok_in(input logic [thlf_pkg::CHAN_W-1:0] ch);
		return (int'(ch) < CHANNELS);
	endfunction

	assign in_ready  = (state_q == S_IDLE);
	assign accept    = in_valid && in_ready;
	assign out_load  = (state_q == S_OUT) && (!out_valid || out_ready);
	assign ch_idx_in = CH_W'(channel);
	assign ch_idx_q  = CH_W'(ch_q);
	assign ch_ok     = (int'(ch_q) < CHANNELS);
	assign cnt_inc   = st_cur.count + 1'b1;
	assign cnt_dec   = st_cur.count - 1'b1;
	assign wr_addr   = ADDR_W'(ch_idx_q * DEPTH + st_cur.wr_ptr);
	assign rd_addr   = ADDR_W'(ch_idx_q * DEPTH + st_cur.rd_ptr);

	// A channel that was never written reads as its reset state.
	always_comb begin
		st_cur = st_rd_q;
		if (!st_rd_vld_q) begin
			st_cur = '0;
			st_cur.empty = 1'b1;
		end
	end

	// Operation on the state of the addressed channel.
	always_comb begin
		st_nxt     = st_cur;
		status_nxt = thlf_pkg::ST_OK;
		ent_we     = 1'b0;
		ent_re     = 1'b0;
		if (!ch_ok || !hist_en_q[ch_q]) begin
			status_nxt = thlf_pkg::ST_DISABLED;
		end else begin
			case (op_q)
				thlf_pkg::OP_PUT: begin
					if (st_cur.count == CNT_FULL) begin
						st_nxt.overflow = 1'b1;
						status_nxt      = thlf_pkg::ST_OVERFLOW;
					end else begin
						ent_we       = 1'b1;
						st_nxt.count = cnt_inc;
						st_nxt.wr_ptr = (st_cur.wr_ptr == PTR_LAST) ? '0 :
						                st_cur.wr_ptr + 1'b1;
						if (intr_every_q[ch_q] ||
						    (CMP_W'(cnt_inc) == CMP_W'(intr_level_q))) begin
							st_nxt.interrupt = 1'b1;
						end
						if (cnt_inc == CNT_FULL) begin
							st_nxt.full = 1'b1;
						end
						st_nxt.empty = 1'b0;
					end
				end
				thlf_pkg::OP_DROP: begin
					if (st_cur.count == '0) begin
						status_nxt = thlf_pkg::ST_EMPTY;
					end else begin
						st_nxt.count  = cnt_dec;
						st_nxt.rd_ptr = (st_cur.rd_ptr == PTR_LAST) ? '0 :
						                st_cur.rd_ptr + 1'b1;
						if (cnt_dec == '0) begin
							st_nxt.empty = 1'b1;
						end
						st_nxt.full = 1'b0;
					end
				end
				thlf_pkg::OP_PEEK: begin
					if (st_cur.count == '0) begin
						status_nxt = thlf_pkg::ST_EMPTY;
					end else begin
						ent_re = 1'b1;
					end
				end
				default: begin
				end
			endcase
		end
	end

	assign st_we = (state_q == S_EXEC) && ch_ok;

	// Per-channel state memory with registered read.
	always_ff @(posedge clk) begin
		if (accept) begin
			st_rd_q <= st_mem[ch_idx_in];
		end
		if (st_we) begin
			st_mem[ch_idx_q] <= st_nxt;
		end
	end

	// Entry store: write on put, registered read on peek.
	always_ff @(posedge clk) begin
		if ((state_q == S_EXEC) && ent_we) begin
			ent_mem[wr_addr] <= ENTRY_BITS'(entry_q);
		end
		if ((state_q == S_EXEC) && ent_re) begin
			ent_rd_q <= ent_mem[rd_addr];
		end
	end

	// Input capture and the result of the update.
	always_ff @(posedge clk) begin
		if (accept) begin
			op_q    <= thlf_pkg::op_t'(operation);
			ch_q    <= channel;
			entry_q <= entry_in;
		end
		if (state_q == S_EXEC) begin
			res_status_q <= status_nxt;
			res_peek_q   <= ent_re;
			res_ovf_q    <= ch_ok && st_nxt.overflow;
			res_intr_q   <= ch_ok && st_nxt.interrupt;
			res_full_q   <= ch_ok && st_nxt.full;
			res_empty_q  <= ch_ok && st_nxt.empty;
			res_count_q  <= ch_ok ? st_nxt.count : '0;
		end
	end

	// Valid bits of the state memory and the configuration registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_vld_q     <= '0;
			st_rd_vld_q  <= 1'b0;
			hist_en_q    <= '0;
			intr_every_q <= '0;
			intr_level_q <= thlf_pkg::INTR_LEVEL_RST;
		end else begin
			if (accept) begin
				st_rd_vld_q <= ch_ok_in(channel) && st_vld_q[ch_idx_in];
			end
			if (st_we) begin
				st_vld_q[ch_idx_q] <= 1'b1;
			end
			if (cfg_we) begin
				case (cfg_addr)
					thlf_pkg::CFG_HIST_EN:    hist_en_q    <= cfg_wdata;
					thlf_pkg::CFG_INTR_EVERY: intr_every_q <= cfg_wdata;
					thlf_pkg::CFG_INTR_LEVEL: intr_level_q <= cfg_wdata[thlf_pkg::LEVEL_W-1:0];
					default: begin
					end
				endcase
			end
		end
	end

	// Sequencer and result register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q        <= S_IDLE;
			out_valid      <= 1'b0;
			status_code    <= '0;
			entry_out      <= '0;
			overflow_flag  <= 1'b0;
			interrupt_flag <= 1'b0;
			full_flag      <= 1'b0;
			empty_flag     <= 1'b0;
			fill_count     <= '0;
		end else begin
			if (out_load) begin
				out_valid <= 1'b1;
			end else if (out_valid && out_ready) begin
				out_valid <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					if (accept) begin
						state_q <= S_EXEC;
					end
				end
				S_EXEC: begin
					state_q <= S_OUT;
				end
				S_OUT: begin
					if (out_load) begin
						status_code    <= res_status_q;
						entry_out      <= res_peek_q ? thlf_pkg::WORD_W'(ent_rd_q) : '0;
						overflow_flag  <= res_ovf_q;
						interrupt_flag <= res_intr_q;
						full_flag      <= res_full_q;
						empty_flag     <= res_empty_q;
						fill_count     <= thlf_pkg::FILL_W'(res_count_q);
						state_q        <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

endmodule

FILE: hw/rtl/thlf_checker.sv
module thlf_checker (
	input logic                           clk,
	input logic                           arst_n,
	input logic                           in_valid,
	input logic                           in_ready,
	input logic [thlf_pkg::OP_W-1:0]      operation,
	input logic [thlf_pkg::CHAN_W-1:0]    channel,
	input logic [thlf_pkg::WORD_W-1:0]    entry_in,
	input logic                           out_valid,
	input logic                           out_ready,
	input logic [1:0]                     status_code,
	input logic [thlf_pkg::WORD_W-1:0]    entry_out,
	input logic                           overflow_flag,
	input logic                           interrupt_flag,
	input logic                           full_flag,
	input logic                           empty_flag,
	input logic [thlf_pkg::FILL_W-1:0]    fill_count,
	input logic                           cfg_we,
	input logic [thlf_pkg::CFG_IDX_W-1:0] cfg_addr,
	input logic [thlf_pkg::CFG_DAT_W-1:0] cfg_wdata
);

	// A stalled result word holds its payload.
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(status_code) &&
		$stable(entry_out) && $stable(fill_count))
		else $error("result word changed while stalled");

	// Only one word is in the block at a time.
	a_one_at_a_time: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !in_ready)
		else $error("second word accepted while busy");

	// An entry word is shown only on a successful operation.
	a_data_only_ok: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (status_code != thlf_pkg::ST_OK) |-> (entry_out == '0))
		else $error("entry word shown on a failed operation");

	// A refused put reports a full ring and the sticky overflow flag.
	a_overflow_flags: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (status_code == thlf_pkg::ST_OVERFLOW) |->
		full_flag && overflow_flag && !empty_flag)
		else $error("overflow status without full and overflow flags");

	// An empty status reports an empty ring.
	a_empty_flags: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (status_code == thlf_pkg::ST_EMPTY) |->
		empty_flag && !full_flag && (fill_count == '0))
		else $error("empty status with a nonempty ring");

endmodule

bind tx_history_list_fifo thlf_checker u_thlf_checker (.*);

FILE: tb/history_fifo_checker.sv
`timescale 1ns / 100ps

// Watches the word, result and register ports of the history FIFO, keeps its own copy
// of the per-channel rings and flags, and compares every result word with the oldest
// predicted one.
module history_fifo_checker
	import thlf_pkg::*;
(
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  in_valid,
	input  logic                  in_ready,
	input  logic [OP_W-1:0]       operation,
	input  logic [CHAN_W-1:0]     channel,
	input  logic [WORD_W-1:0]     entry_in,
	input  logic                  out_valid,
	input  logic                  out_ready,
	input  logic [1:0]            status_code,
	input  logic [WORD_W-1:0]     entry_out,
	input  logic                  overflow_flag,
	input  logic                  interrupt_flag,
	input  logic                  full_flag,
	input  logic                  empty_flag,
	input  logic [FILL_W-1:0]     fill_count,
	input  logic                  cfg_we,
	input  logic [CFG_IDX_W-1:0]  cfg_addr,
	input  logic [CFG_DAT_W-1:0]  cfg_wdata,
	output int unsigned           mismatches,
	output int unsigned           pending
);

	localparam int PTR_W = $clog2(DEPTH_DEF);

	typedef struct {
		logic [1:0]        status;
		logic [WORD_W-1:0] entry;
		logic              ovf;
		logic              irq;
		logic              full;
		logic              empty;
		logic [FILL_W-1:0] fill;
	} hist_result_t;

	// Shadow copy of the rings, pointers, counts and flags of every channel.
	logic [WORD_W-1:0]       entry_mem [CHANNELS_DEF][DEPTH_DEF];
	logic [PTR_W-1:0]        wr_ptr [CHANNELS_DEF];
	logic [PTR_W-1:0]        rd_ptr [CHANNELS_DEF];
	logic [FILL_W-1:0]       count_q [CHANNELS_DEF];
	logic [CHANNELS_DEF-1:0] ovf_bits;
	logic [CHANNELS_DEF-1:0] irq_bits;
	logic [CHANNELS_DEF-1:0] full_bits;
	logic [CHANNELS_DEF-1:0] empty_bits;

	// Shadow copy of the registers.
	logic [CFG_DAT_W-1:0] hist_en;
	logic [CFG_DAT_W-1:0] irq_every;
	logic [LEVEL_W-1:0]   irq_level;

	hist_result_t result_q [$];
	hist_result_t want;

	// Applies one word to the shadow state and returns the result it must give.
	function automatic hist_result_t apply_history_op(logic [OP_W-1:0] op,
			logic [CHAN_W-1:0] ch, logic [WORD_W-1:0] word);
		hist_result_t res;
		res.status = ST_OK;
		res.entry  = '0;
		if (!hist_en[ch]) begin
			res.status = ST_DISABLED;
		end else begin
			case (op)
				OP_PUT: begin
					if (count_q[ch] >= DEPTH_DEF) begin
						ovf_bits[ch] = 1'b1;
						res.status   = ST_OVERFLOW;
					end else begin
						entry_mem[ch][wr_ptr[ch]] = word;
						count_q[ch] = count_q[ch] + 1'b1;
						wr_ptr[ch] = (wr_ptr[ch] == DEPTH_DEF - 1) ? '0 : wr_ptr[ch] + 1'b1;
						if (irq_every[ch] || count_q[ch] == irq_level)
							irq_bits[ch] = 1'b1;
						if (count_q[ch] >= DEPTH_DEF)
							full_bits[ch] = 1'b1;
						empty_bits[ch] = 1'b0;
					end
				end
				OP_DROP: begin
					if (count_q[ch] == 0) begin
						res.status = ST_EMPTY;
					end else begin
						count_q[ch] = count_q[ch] - 1'b1;
						rd_ptr[ch] = (rd_ptr[ch] == DEPTH_DEF - 1) ? '0 : rd_ptr[ch] + 1'b1;
						if (count_q[ch] == 0)
							empty_bits[ch] = 1'b1;
						full_bits[ch] = 1'b0;
					end
				end
				OP_PEEK: begin
					if (count_q[ch] == 0)
						res.status = ST_EMPTY;
					else
						res.entry = entry_mem[ch][rd_ptr[ch]];
				end
				// An unused code leaves the channel as it is.
				default: ;
			endcase
		end
		res.ovf   = ovf_bits[ch];
		res.irq   = irq_bits[ch];
		res.full  = full_bits[ch];
		res.empty = empty_bits[ch];
		res.fill  = count_q[ch];
		return res;
	endfunction

	task automatic check_field(string name, logic [WORD_W-1:0] exp_val,
			logic [WORD_W-1:0] act_val);
		if (act_val !== exp_val) begin
			$error("%s: expected 0x%0h, got 0x%0h", name, exp_val, act_val);
			mismatches++;
		end
	endtask

	// Track register writes, compare result words and predict accepted words.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int c = 0; c < CHANNELS_DEF; c++) begin
				wr_ptr[c]  = '0;
				rd_ptr[c]  = '0;
				count_q[c] = '0;
			end
			ovf_bits   = '0;
			irq_bits   = '0;
			full_bits  = '0;
			empty_bits = '1;
			hist_en    = '0;
			irq_every  = '0;
			irq_level  = INTR_LEVEL_RST;
			result_q.delete();
			mismatches = 0;
			pending    = 0;
		end else begin
			if (cfg_we) begin
				case (cfg_addr)
					CFG_HIST_EN:    hist_en   = cfg_wdata;
					CFG_INTR_EVERY: irq_every = cfg_wdata;
					CFG_INTR_LEVEL: irq_level = cfg_wdata[LEVEL_W-1:0];
					default: ;
				endcase
			end

			// A result word belongs to an earlier word, so it is matched before the
			// word accepted at this edge is predicted.
			if (out_valid && out_ready) begin
				if (result_q.size() == 0) begin
					$error("result word with no prediction waiting");
					mismatches++;
				end else begin
					want = result_q.pop_front();
					check_field("status_code", want.status, status_code);
					check_field("entry_out", want.entry, entry_out);
					check_field("overflow_flag", want.ovf, overflow_flag);
					check_field("interrupt_flag", want.irq, interrupt_flag);
					check_field("full_flag", want.full, full_flag);
					check_field("empty_flag", want.empty, empty_flag);
					check_field("fill_count", want.fill, fill_count);
				end
			end

			if (in_valid && in_ready)
				result_q.push_back(apply_history_op(operation, channel, entry_in));

			pending = result_q.size();
		end
	end

endmodule

FILE: tb/tx_history_list_fifo_tb.sv
`timescale 1ns / 100ps

module tx_history_list_fifo_tb;
	import thlf_pkg::*;

	// Codes the block does not define; the block must still handle them.
	localparam logic [OP_W-1:0]      OP_UNUSED  = 2'd3;
	localparam logic [CFG_IDX_W-1:0] CFG_UNUSED = 2'd3;

	typedef enum {MIX_FILL, MIX_DRAIN, MIX_EVEN} mix_t;

	logic                  clk = 1'b0;
	logic                  arst_n;
	logic                  in_valid;
	logic                  in_ready;
	logic [OP_W-1:0]       operation;
	logic [CHAN_W-1:0]     channel;
	logic [WORD_W-1:0]     entry_in;
	logic                  out_valid;
	logic                  out_ready;
	logic [1:0]            status_code;
	logic [WORD_W-1:0]     entry_out;
	logic                  overflow_flag;
	logic                  interrupt_flag;
	logic                  full_flag;
	logic                  empty_flag;
	logic [FILL_W-1:0]     fill_count;
	logic                  cfg_we;
	logic [CFG_IDX_W-1:0]  cfg_addr;
	logic [CFG_DAT_W-1:0]  cfg_wdata;
	int unsigned           mismatches;
	int unsigned           pending;
	bit                    quiet = 1'b0;

	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	tx_history_list_fifo i_dut (
		.clk            (clk),
		.arst_n         (arst_n),
		.in_valid       (in_valid),
		.in_ready       (in_ready),
		.operation      (operation),
		.channel        (channel),
		.entry_in       (entry_in),
		.out_valid      (out_valid),
		.out_ready      (out_ready),
		.status_code    (status_code),
		.entry_out      (entry_out),
		.overflow_flag  (overflow_flag),
		.interrupt_flag (interrupt_flag),
		.full_flag      (full_flag),
		.empty_flag     (empty_flag),
		.fill_count     (fill_count),
		.cfg_we         (cfg_we),
		.cfg_addr       (cfg_addr),
		.cfg_wdata      (cfg_wdata)
	);

	history_fifo_checker i_history_chk (
		.clk            (clk),
		.arst_n         (arst_n),
		.in_valid       (in_valid),
		.in_ready       (in_ready),
		.operation      (operation),
		.channel        (channel),
		.entry_in       (entry_in),
		.out_valid      (out_valid),
		.out_ready      (out_ready),
		.status_code    (status_code),
		.entry_out      (entry_out),
		.overflow_flag  (overflow_flag),
		.interrupt_flag (interrupt_flag),
		.full_flag      (full_flag),
		.empty_flag     (empty_flag),
		.fill_count     (fill_count),
		.cfg_we         (cfg_we),
		.cfg_addr       (cfg_addr),
		.cfg_wdata      (cfg_wdata),
		.mismatches     (mismatches),
		.pending        (pending)
	);

	// Result side stalls in random bursts; it stays ready once the run goes quiet.
	initial begin
		int unsigned run_len;
		run_len = 0;
		out_ready <= 1'b0;
		forever begin
			@(posedge clk);
			if (quiet) begin
				out_ready <= 1'b1;
				run_len = 0;
			end else if (run_len > 0) begin
				run_len--;
			end else if ($urandom_range(0, 3) == 0) begin
				out_ready <= 1'b0;
				run_len = $urandom_range(0, 14);
			end else begin
				out_ready <= 1'b1;
				run_len = $urandom_range(0, 20);
			end
		end
	end

	// Offers one word after an optional idle burst and waits until it is taken.
	// Valid is left high so that a following word can go out back to back.
	task automatic send_word(logic [OP_W-1:0] op, logic [CHAN_W-1:0] ch,
			logic [WORD_W-1:0] word);
		int unsigned gap;
		gap = 0;
		if (!quiet && $urandom_range(0, 3) == 0)
			gap = $urandom_range(1, 15);
		if (gap != 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid  <= 1'b1;
		operation <= op;
		channel   <= ch;
		entry_in  <= word;
		do @(posedge clk); while (!in_ready);
	endtask

	// Stops offering words and waits until every result word has come out.
	task automatic wait_idle();
		in_valid <= 1'b0;
		do @(negedge clk); while (pending != 0);
		repeat (4) @(posedge clk);
	endtask

	// Writes all registers, with a write to the unused index mixed in first.
	task automatic set_config(logic [CFG_DAT_W-1:0] en_mask, logic [CFG_DAT_W-1:0] every_mask,
			logic [LEVEL_W-1:0] level);
		cfg_we    <= 1'b1;
		cfg_addr  <= CFG_UNUSED;
		cfg_wdata <= 8'($urandom);
		@(posedge clk);
		cfg_addr  <= CFG_HIST_EN;
		cfg_wdata <= en_mask;
		@(posedge clk);
		cfg_addr  <= CFG_INTR_EVERY;
		cfg_wdata <= every_mask;
		@(posedge clk);
		cfg_addr  <= CFG_INTR_LEVEL;
		cfg_wdata <= {4'($urandom_range(0, 15)), level};
		@(posedge clk);
		cfg_we    <= 1'b0;
	endtask

	// Random words in runs that mostly fill, mostly drain or mix one focus channel,
	// so that rings reach full, overflow and empty again.
	task automatic run_random(int unsigned n_words);
		mix_t              mix;
		logic [CHAN_W-1:0] focus;
		int unsigned       pick;
		logic [OP_W-1:0]   op;
		logic [CHAN_W-1:0] ch;
		logic [WORD_W-1:0] word;
		mix   = MIX_EVEN;
		focus = '0;
		for (int unsigned i = 0; i < n_words; i++) begin
			if (i % 24 == 0) begin
				mix   = mix_t'($urandom_range(0, 2));
				focus = 3'($urandom_range(0, 7));
			end
			pick = $urandom_range(0, 99);
			if (pick < 3)
				op = OP_UNUSED;
			else if (mix == MIX_FILL)
				op = (pick < 75) ? OP_PUT : ((pick < 88) ? OP_PEEK : OP_DROP);
			else if (mix == MIX_DRAIN)
				op = (pick < 20) ? OP_PUT : ((pick < 45) ? OP_PEEK : OP_DROP);
			else
				op = (pick < 45) ? OP_PUT : ((pick < 70) ? OP_PEEK : OP_DROP);
			ch = ($urandom_range(0, 3) != 0) ? focus : 3'($urandom_range(0, 7));
			case ($urandom_range(0, 15))
				0:       word = '0;
				1:       word = '1;
				default: word = $urandom;
			endcase
			send_word(op, ch, word);
		end
	endtask

	// Main stimulus and verdict.
	initial begin
		arst_n    <= 1'b0;
		in_valid  <= 1'b0;
		operation <= OP_PUT;
		channel   <= '0;
		entry_in  <= '0;
		cfg_we    <= 1'b0;
		cfg_addr  <= CFG_HIST_EN;
		cfg_wdata <= '0;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;

		// Directed part: channel 0 interrupts on every put, channel 1 at the highest
		// level, channel 7 is disabled.
		set_config(8'h7F, 8'h01, 4'd8);
		send_word(OP_PEEK, 3'd0, '1);
		send_word(OP_DROP, 3'd0, '0);
		for (int i = 0; i < 9; i++)
			send_word(OP_PUT, 3'd0, (i == 0) ? 32'h0 : (i == 1) ? 32'hFFFF_FFFF :
				(i == 2) ? 32'hAAAA_AAAA : (i == 3) ? 32'h5555_5555 : $urandom);
		send_word(OP_PEEK, 3'd0, $urandom);
		send_word(OP_DROP, 3'd0, $urandom);
		send_word(OP_UNUSED, 3'd0, '1);
		send_word(OP_PUT, 3'd7, $urandom);
		send_word(OP_PEEK, 3'd7, $urandom);
		for (int i = 0; i < 9; i++)
			send_word(OP_PUT, 3'd1, $urandom);

		// Random phases over several register settings, extremes among them.
		wait_idle();
		set_config(8'hFF, 8'h00, 4'd1);
		run_random(200);

		// A level of zero never matches a count.
		wait_idle();
		set_config(8'($urandom), 8'($urandom), 4'd0);
		run_random(180);

		wait_idle();
		set_config(8'hFF, 8'hFF, 4'd8);
		run_random(150);

		// Every channel disabled, and a level above the ring depth.
		wait_idle();
		set_config(8'h00, 8'h00, 4'd15);
		run_random(40);

		wait_idle();
		set_config(8'($urandom), 8'($urandom), 4'($urandom_range(1, 8)));
		run_random(200);

		// Last part without any idling on either side.
		wait_idle();
		quiet = 1'b1;
		set_config(8'hFF, 8'($urandom), 4'($urandom_range(1, 8)));
		run_random(230);

		wait_idle();
		repeat (10) @(posedge clk);
		@(negedge clk);
		if (mismatches == 0)
			$display("No mismatches found");
		else
			$display("Mismatches found");
		$finish;
	end

	// Guard against a hang.
	initial begin
		#3_000_000;
		$display("Mismatches found");
		$finish;
	end

endmodule
